### rtl/assert_macros.svh
// Assertion macros used by the semaphore RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/csemq_pkg.sv
// Types and constants of the counting semaphore with waiter queue.
package csemq_pkg;

    localparam int TASK_W    = 4;
    localparam int AMT_W     = 16;
    localparam int KIND_W    = 3;
    localparam int TASK_SPACE = 1 << TASK_W;

    typedef enum logic [KIND_W-1:0] {
        K_GRANTED  = 3'd0,
        K_BLOCKED  = 3'd1,
        K_WOKEN    = 3'd2,
        K_PUT_DONE = 3'd3,
        K_REFUSED  = 3'd4
    } t_kind;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One waiter list entry.
    typedef struct packed {
        logic [TASK_W-1:0] tid;
        logic [AMT_W-1:0]  need;
    } t_entry;

endpackage

### rtl/counting_semaphore_waiter_queue.sv
// Counting semaphore with an ordered waiter list held in a one-port-write memory.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+----------------------------------------
//   in      | i_in_valid  | o_in_ready   | i_opcode, i_task_id, i_amount
//   out     | o_out_valid | i_out_ready  | o_kind, o_result_task, o_count_now, o_last
//   cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_data
//
// A get gives one result beat. A put walks the list: the walk reads one list entry
// per cycle from the waiter memory unless a wake beat waits on a stalled output
// (registered read, next read issued while the current entry is judged) and
// compacts the kept entries in place, then the put_done beat closes it.
// Synchronous active-low reset; the waiter memory needs no clearing pass.
// A stall holds the walk at a wake or put_done; input is taken only while idle.
module counting_semaphore_waiter_queue #(
    parameter int MAX_TASKS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [csemq_pkg::TASK_W-1:0]      i_task_id,
    input  logic [csemq_pkg::AMT_W-1:0]       i_amount,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output csemq_pkg::t_kind                  o_kind,
    output logic [csemq_pkg::TASK_W-1:0]      o_result_task,
    output logic [csemq_pkg::AMT_W-1:0]       o_count_now,
    output logic                              o_last,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [csemq_pkg::AMT_W-1:0]       i_cfg_data
);
    import csemq_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = (COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W;
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TW = $clog2(MAX_TASKS + 1);
    localparam logic [CW:0] COUNT_MAX = (CW+1)'({COUNT_BITS{1'b1}});

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // waiter list memory
    t_entry r_mem [MAX_TASKS];
    t_entry r_rd_data;

    t_state                  r_state, n_state;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic [COUNT_BITS-1:0]   r_budget, n_budget;
    logic [TW-1:0]           r_total, n_total;
    logic [TW-1:0]           r_scan, n_scan;
    logic [TW-1:0]           r_kept, n_kept;
    logic                    r_pend, n_pend;
    logic [TASK_SPACE-1:0]   r_waiting, n_waiting;

    logic                    r_out_valid, n_out_valid;
    t_kind                   r_kind, n_kind;
    logic [TASK_W-1:0]       r_otask, n_otask;
    logic [AMT_W-1:0]        r_ocount, n_ocount;
    logic                    r_olast, n_olast;

    logic                    out_free;
    logic                    in_fire;
    logic                    cfg_fire;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    t_entry                  wr_data;
    logic [CW:0]             put_sum;
    logic [CW-1:0]           cnt_ext;
    logic [CW-1:0]           bud_ext;
    logic [CW-1:0]           need_ext;
    logic                    fits;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_result_task = r_otask;
    assign o_count_now   = r_ocount;
    assign o_last        = r_olast;

    assign cnt_ext  = CW'(r_count);
    assign bud_ext  = CW'(r_budget);
    assign need_ext = CW'(r_rd_data.need);
    assign fits     = (r_budget != '0) && (need_ext <= bud_ext);
    assign put_sum  = (CW+1)'(r_count) + (CW+1)'(i_amount);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_budget    = r_budget;
        n_total     = r_total;
        n_scan      = r_scan;
        n_kept      = r_kept;
        n_pend      = r_pend;
        n_waiting   = r_waiting;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_otask     = r_otask;
        n_ocount    = r_ocount;
        n_olast     = r_olast;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_total[AW-1:0];
        wr_data     = '{tid: i_task_id, need: i_amount};

        unique case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    n_count = COUNT_BITS'(CW'(i_cfg_data));
                end
                if (in_fire) begin
                    n_out_valid = 1'b1;
                    n_olast     = 1'b1;
                    n_otask     = i_task_id;
                    if (i_opcode == OP_GET) begin
                        priority if (r_waiting[i_task_id]) begin
                            n_kind = K_REFUSED;
                        end else if (cnt_ext >= CW'(i_amount)) begin
                            n_count = COUNT_BITS'(cnt_ext - CW'(i_amount));
                            n_kind  = K_GRANTED;
                        end else if (r_total >= TW'(MAX_TASKS)) begin
                            n_kind = K_REFUSED;
                        end else begin
                            wr_en                = 1'b1;
                            n_total              = r_total + 1'b1;
                            n_waiting[i_task_id] = 1'b1;
                            n_kind               = K_BLOCKED;
                        end
                    end else begin
                        // saturating add; budget starts at the new count
                        n_count     = (put_sum > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                                            : COUNT_BITS'(put_sum);
                        n_budget    = n_count;
                        n_out_valid = r_out_valid && !i_out_ready;
                        rd_en       = (r_total != '0);
                        rd_addr     = '0;
                        n_pend      = (r_total != '0);
                        n_scan      = (r_total != '0) ? TW'(1) : '0;
                        n_kept      = '0;
                        n_state     = S_WALK;
                    end
                    n_ocount = AMT_W'(CW'(n_count));
                end
            end
            S_WALK: begin
                if (r_pend) begin
                    if (!fits || out_free) begin
                        if (fits) begin
                            n_budget                  = COUNT_BITS'(bud_ext - need_ext);
                            n_waiting[r_rd_data.tid]  = 1'b0;
                            n_out_valid               = 1'b1;
                            n_kind                    = K_WOKEN;
                            n_otask                   = r_rd_data.tid;
                            n_olast                   = 1'b0;
                            n_ocount                  = AMT_W'(cnt_ext);
                        end else begin
                            // kept entries slide down; kept never passes scan
                            wr_en   = 1'b1;
                            wr_addr = r_kept[AW-1:0];
                            wr_data = r_rd_data;
                            n_kept  = r_kept + 1'b1;
                        end
                        if (r_scan < r_total) begin
                            rd_en   = 1'b1;
                            rd_addr = r_scan[AW-1:0];
                            n_scan  = r_scan + 1'b1;
                        end else begin
                            n_pend = 1'b0;
                        end
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = K_PUT_DONE;
                    n_otask     = '0;
                    n_olast     = 1'b1;
                    n_ocount    = AMT_W'(cnt_ext);
                    n_total     = r_kept;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_waiting   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_pend      <= n_pend;
            r_waiting   <= n_waiting;
            r_out_valid <= n_out_valid;
        end
        r_budget <= n_budget;
        r_scan   <= n_scan;
        r_kept   <= n_kept;
        r_kind   <= n_kind;
        r_otask  <= n_otask;
        r_ocount <= n_ocount;
        r_olast  <= n_olast;
    end

    `ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= TW'(MAX_TASKS),
        "waiter total exceeds list depth")
    `ASSERT_NOW(a_kept_behind_scan, i_clk, i_rst_n, r_state == S_WALK,
        (r_kept <= r_scan) && (r_scan <= r_total), "walk compaction overtook the read")
    `ASSERT_NOW(a_waiting_matches, i_clk, i_rst_n, r_state == S_IDLE,
        $countones(r_waiting) == int'(r_total), "waiting flags disagree with total")
    `ASSERT_NEXT(a_put_done_closes, i_clk, i_rst_n,
        (r_state == S_WALK) && !r_pend && out_free,
        r_out_valid && r_olast && (r_kind == K_PUT_DONE) && (r_state == S_IDLE),
        "walk end did not issue put_done")

endmodule
